FILE: design/forward_substring_search_top_defines.svh
// Assertion macros for the forward substring search block.
// Taken in by the top level by include; depends on nothing else.
`ifndef FORWARD_SUBSTRING_SEARCH_TOP_DEFINES_SVH
`define FORWARD_SUBSTRING_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication, quiet while reset is high
`define FSS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fss assertion failed");

// Next-cycle implication, quiet while reset is high
`define FSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fss assertion failed");

`endif

FILE: design/fss_pkg.sv
// Shared types, codes and helpers of the forward substring search block.
// Used by the channel interfaces and the top level; depends on nothing.
package fss_pkg;

   localparam int CHAR_W = 16;
   localparam int POS_W  = 16;

   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [POS_W-1:0]  pos_type;

   // Kind of a request item
   typedef enum logic [0:0] {
      REQ_PATTERN = 1'b0,
      REQ_TEXT    = 1'b1
   } req_kind_type;

   // Configuration register indexes
   typedef logic [0:0] csr_index_type;
   localparam csr_index_type CSR_IGNORE_CASE  = 1'b0;
   localparam csr_index_type CSR_START_OFFSET = 1'b1;

   localparam char_type UPPER_A = 16'h0041;
   localparam char_type UPPER_Z = 16'h005A;
   localparam char_type CASE_OFFSET = 16'h0020;

   // Fold ASCII A-Z to lower case when enabled
   function automatic char_type fold_char(input char_type c, input logic enable);
      char_type r;
      r = c;
      if (enable && c >= UPPER_A && c <= UPPER_Z) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

endpackage

FILE: design/fss_if.sv
// Request and response channel interfaces of the forward substring search block.
// Depends on fss_pkg for the payload types.
interface fss_req_if;
   logic                  valid;
   logic                  ready;
   fss_pkg::req_kind_type req_type;
   fss_pkg::char_type     char_code;
   logic                  last_item;

   modport source (output valid, output req_type, output char_code, output last_item,
                   input ready);
   modport sink   (input valid, input req_type, input char_code, input last_item,
                   output ready);
endinterface

interface fss_rsp_if;
   logic             valid;
   logic             ready;
   logic             found;
   fss_pkg::pos_type match_index;
   logic             pattern_error;

   modport source (output valid, output found, output match_index, output pattern_error,
                   input ready);
   modport sink   (input valid, input found, input match_index, input pattern_error,
                   output ready);
endinterface

FILE: design/forward_substring_search_top.sv
// Top level of the forward substring search block: pattern shift store, text window,
// parallel window compare and result register. Depends on fss_pkg, fss_if.sv and
// forward_substring_search_top_defines.svh.
//
//   channel  | direction | carries
//   ---------+-----------+-------------------------------------------------
//   req_ch   | in        | pattern or text character, last_item marker
//   rsp_ch   | out       | found flag, match start index, pattern error
//   csr_*    | in        | ignore_case, start_offset writes (no read-back)
//
// One item per cycle while no stalled result holds the input register: an item is
// registered in the input register when accepted, and one pass of compare logic across
// all PATTERN_MAX window slots then loads the result register from that item.
// Reset is synchronous; the pattern and window stores need no clearing.
// A stalled result stops the input register only when the waiting item has a result.
`include "forward_substring_search_top_defines.svh"

module forward_substring_search_top #(
   parameter int PATTERN_MAX = 16,
   parameter int TEXT_MAX    = 65536
) (
   input  logic                   clock,
   input  logic                   reset,
   fss_req_if.sink                req_ch,
   fss_rsp_if.source              rsp_ch,
   input  logic                   csr_wr_en,
   input  fss_pkg::csr_index_type csr_index,
   input  fss_pkg::char_type      csr_wr_data
);

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);
   localparam int POS_W_EXT = fss_pkg::POS_W + 1;
   localparam int POS_CAP_INT = (TEXT_MAX - 1 < 65535) ? (TEXT_MAX - 1) : 65535;
   localparam fss_pkg::pos_type POS_CAP = fss_pkg::POS_W'(POS_CAP_INT);
   localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(PATTERN_MAX);

   // Configuration registers
   logic             ignore_case_ff;
   fss_pkg::pos_type start_offset_ff;

   // Input register
   logic                  s1_valid_ff, s1_valid_in;
   fss_pkg::req_kind_type s1_type_ff;
   fss_pkg::char_type     s1_char_ff;
   logic                  s1_last_ff;

   // Search state
   fss_pkg::char_type pat_ff [PATTERN_MAX];
   fss_pkg::char_type win_ff [PATTERN_MAX];
   fss_pkg::char_type win_in [PATTERN_MAX];
   logic [LEN_W-1:0]  pat_len_ff, pat_len_in;
   logic              pat_ovf_ff, pat_ovf_in;
   logic              fresh_ff, fresh_in;
   fss_pkg::pos_type  pos_ff, pos_in;
   logic              reported_ff, reported_in;

   // Result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_found_ff;
   fss_pkg::pos_type rsp_index_ff;
   logic             rsp_error_ff;

   // Compare results
   logic [PATTERN_MAX-1:0] slot_ok;
   logic [POS_W_EXT-1:0]   end_plus1;
   logic [POS_W_EXT-1:0]   start_ext;
   logic                   hit;
   logic                   emit_match;
   logic                   emit_nf;
   logic                   s1_emit;
   logic                   s1_go;
   logic                   is_text;
   logic                   load_pat;
   logic [LEN_W-1:0]       base_len;
   logic                   base_ovf;

   // Hold configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         ignore_case_ff  <= 1'b0;
         start_offset_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            fss_pkg::CSR_IGNORE_CASE:  ignore_case_ff  <= csr_wr_data[0];
            fss_pkg::CSR_START_OFFSET: start_offset_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Shift the text window: slot 0 takes the newest character
   always_comb begin
      win_in[0] = s1_char_ff;
      for (int k = 1; k < PATTERN_MAX; k++) begin
         win_in[k] = win_ff[k-1];
      end
   end

   // Compare every live window slot with its pattern slot at once
   always_comb begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
         slot_ok[k] = (LEN_W'(k) >= pat_len_ff) ||
                      (fss_pkg::fold_char(win_in[k], ignore_case_ff) ==
                       fss_pkg::fold_char(pat_ff[k], ignore_case_ff));
      end
   end

   assign is_text   = (s1_type_ff == fss_pkg::REQ_TEXT);
   assign end_plus1 = {1'b0, pos_ff} + POS_W_EXT'(1);
   assign start_ext = end_plus1 - POS_W_EXT'(pat_len_ff);
   assign hit = (pat_len_ff != '0) && !pat_ovf_ff &&
                (end_plus1 >= POS_W_EXT'(pat_len_ff)) &&
                (start_ext >= {1'b0, start_offset_ff}) && (&slot_ok);
   assign emit_match = is_text && hit && !reported_ff;
   assign emit_nf    = is_text && s1_last_ff && !reported_ff && !hit;
   assign s1_emit    = emit_match || emit_nf;

   // Advance the input register unless its result cannot be stored
   assign s1_go        = s1_valid_ff && (!s1_emit || !rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_go;
   assign s1_valid_in  = (req_ch.valid && req_ch.ready) || (s1_valid_ff && !s1_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         s1_type_ff <= req_ch.req_type;
         s1_char_ff <= req_ch.char_code;
         s1_last_ff <= req_ch.last_item;
      end
   end

   // Next search state
   always_comb begin
      base_len    = fresh_ff ? '0 : pat_len_ff;
      base_ovf    = fresh_ff ? 1'b0 : pat_ovf_ff;
      load_pat    = 1'b0;
      pat_len_in  = pat_len_ff;
      pat_ovf_in  = pat_ovf_ff;
      fresh_in    = fresh_ff;
      pos_in      = pos_ff;
      reported_in = reported_ff;
      if (s1_go) begin
         if (!is_text) begin
            // Pattern character: a fresh pattern drops any text in progress
            pat_len_in = base_len;
            pat_ovf_in = base_ovf;
            if (fresh_ff) begin
               pos_in      = '0;
               reported_in = 1'b0;
            end
            if (base_len < LEN_FULL) begin
               load_pat   = 1'b1;
               pat_len_in = base_len + LEN_W'(1);
            end else begin
               pat_ovf_in = 1'b1;
            end
            fresh_in = s1_last_ff;
         end else if (s1_last_ff) begin
            pos_in      = '0;
            reported_in = 1'b0;
         end else begin
            reported_in = reported_ff || emit_match;
            if (pos_ff < POS_CAP) begin
               pos_in = pos_ff + fss_pkg::POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_len_ff  <= '0;
         pat_ovf_ff  <= 1'b0;
         fresh_ff    <= 1'b1;
         pos_ff      <= '0;
         reported_ff <= 1'b0;
      end else begin
         pat_len_ff  <= pat_len_in;
         pat_ovf_ff  <= pat_ovf_in;
         fresh_ff    <= fresh_in;
         pos_ff      <= pos_in;
         reported_ff <= reported_in;
      end
   end

   // Pattern store shifts like the window, so slot k pairs with window slot k
   always_ff @(posedge clock) begin
      if (load_pat) begin
         pat_ff[0] <= s1_char_ff;
         for (int k = 1; k < PATTERN_MAX; k++) begin
            pat_ff[k] <= pat_ff[k-1];
         end
      end
   end

   // Window holds only characters of the current text where it is compared
   always_ff @(posedge clock) begin
      if (s1_go && is_text) begin
         for (int k = 0; k < PATTERN_MAX; k++) begin
            win_ff[k] <= win_in[k];
         end
      end
   end

   // Result register
   assign rsp_valid_in = (s1_go && s1_emit) || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_emit) begin
         rsp_found_ff <= emit_match;
         rsp_index_ff <= emit_match ? start_ext[fss_pkg::POS_W-1:0] : '0;
         rsp_error_ff <= emit_nf && pat_ovf_ff;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.found         = rsp_found_ff;
   assign rsp_ch.match_index   = rsp_index_ff;
   assign rsp_ch.pattern_error = rsp_error_ff;

   // A match never carries the pattern error flag
   `FSS_ASSERT_SAME(a_match_no_error, clock, reset,
      rsp_valid_ff && rsp_found_ff, !rsp_error_ff)

   // A not-found report carries index zero
   `FSS_ASSERT_SAME(a_nf_index_zero, clock, reset,
      rsp_valid_ff && !rsp_found_ff, rsp_index_ff == '0)

   // A match mid-text marks the text as reported
   `FSS_ASSERT_NEXT(a_match_marks, clock, reset,
      s1_go && emit_match && !s1_last_ff, reported_ff)

   // Pattern length stays within the store
   `FSS_ASSERT_SAME(a_len_bound, clock, reset, 1'b1, pat_len_ff <= LEN_FULL)

endmodule

FILE: tb/forward_substring_search_checker.sv
`timescale 1ns / 1ps
// Result checker for the forward substring search block: predicts each search result.
// Depends on fss_pkg and the channel interfaces in fss_if.sv.
module forward_substring_search_checker #(
   parameter int PATTERN_MAX = 16,
   parameter int TEXT_MAX    = 65536
) (
   input  logic                   clock,
   input  logic                   reset,
   fss_req_if                     req_ch,
   fss_rsp_if                     rsp_ch,
   input  logic                   csr_wr_en,
   input  fss_pkg::csr_index_type csr_index,
   input  fss_pkg::char_type      csr_wr_data,
   output int                     mismatch_count,
   output int                     pending_count
);

   localparam int POS_CAP = (TEXT_MAX - 1 < 65535) ? TEXT_MAX - 1 : 65535;

   typedef struct packed {
      logic             found;
      fss_pkg::pos_type match_index;
      logic             pattern_error;
   } search_result_type;

   // Shadow of the configuration registers
   logic              fold_en;
   fss_pkg::pos_type  min_start;

   // Shadow of the pattern store and the text window
   fss_pkg::char_type pat_mem [PATTERN_MAX];
   int                pat_len;
   logic              pat_over;
   logic              pat_fresh;
   fss_pkg::char_type win [PATTERN_MAX];
   int                text_pos;
   logic              match_seen;

   search_result_type expected_q[$];

   // Lower ASCII capitals when case folding is on
   function automatic fss_pkg::char_type to_lower(input fss_pkg::char_type c);
      if (fold_en && c >= fss_pkg::UPPER_A && c <= fss_pkg::UPPER_Z) begin
         return c + fss_pkg::CASE_OFFSET;
      end
      return c;
   endfunction

   function automatic void clear_text();
      foreach (win[k]) begin
         win[k] = '0;
      end
      text_pos   = 0;
      match_seen = 1'b0;
   endfunction

   // Advance the shadow state by one item; return 1 when the item yields a result
   function automatic bit predict_search(input fss_pkg::req_kind_type kind,
                                         input fss_pkg::char_type code,
                                         input logic last_flag,
                                         output search_result_type res);
      int start;
      bit hit;
      bit emit;
      emit = 1'b0;
      res  = '0;
      if (kind == fss_pkg::REQ_PATTERN) begin
         if (pat_fresh) begin
            pat_len  = 0;
            pat_over = 1'b0;
            clear_text();
            pat_fresh = 1'b0;
         end
         if (pat_len < PATTERN_MAX) begin
            pat_mem[pat_len] = code;
            pat_len++;
         end else begin
            pat_over = 1'b1;
         end
         if (last_flag) begin
            pat_fresh = 1'b1;
         end
         return 1'b0;
      end

      // Shift the text window; slot 0 holds the newest character
      for (int k = PATTERN_MAX - 1; k > 0; k--) begin
         win[k] = win[k-1];
      end
      win[0] = code;

      if (pat_len > 0 && !pat_over && text_pos + 1 >= pat_len) begin
         start = text_pos + 1 - pat_len;
         if (start >= int'(min_start)) begin
            hit = 1'b1;
            for (int k = 0; k < pat_len; k++) begin
               if (to_lower(win[k]) != to_lower(pat_mem[pat_len-1-k])) begin
                  hit = 1'b0;
               end
            end
            if (hit && !match_seen) begin
               res.found         = 1'b1;
               res.match_index   = fss_pkg::pos_type'(start);
               res.pattern_error = 1'b0;
               match_seen        = 1'b1;
               emit              = 1'b1;
            end
         end
      end

      if (text_pos < POS_CAP) begin
         text_pos++;
      end

      // Report not-found at text end unless a match already went out
      if (last_flag) begin
         if (!match_seen) begin
            res.found         = 1'b0;
            res.match_index   = '0;
            res.pattern_error = pat_over;
            emit              = 1'b1;
         end
         clear_text();
      end
      return emit;
   endfunction

   // Track config writes, predict on accepted inputs, compare accepted results
   always @(posedge clock) begin : watch
      search_result_type want;
      search_result_type got;
      if (reset) begin
         fold_en   = 1'b0;
         min_start = '0;
         pat_len   = 0;
         pat_over  = 1'b0;
         pat_fresh = 1'b1;
         clear_text();
         expected_q.delete();
         mismatch_count = 0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == fss_pkg::CSR_IGNORE_CASE) begin
               fold_en = csr_wr_data[0];
            end else if (csr_index == fss_pkg::CSR_START_OFFSET) begin
               min_start = csr_wr_data;
            end
         end
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
            if (predict_search(req_ch.req_type, req_ch.char_code, req_ch.last_item, want)) begin
               expected_q.push_back(want);
            end
         end
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got.found         = rsp_ch.found;
            got.match_index   = rsp_ch.match_index;
            got.pattern_error = rsp_ch.pattern_error;
            if (expected_q.size() == 0) begin
               if (mismatch_count < 10) begin
                  $display("%0t: unexpected result found=%0d index=%0d error=%0d", $realtime,
                           got.found, got.match_index, got.pattern_error);
               end
               mismatch_count++;
            end else begin
               want = expected_q.pop_front();
               if (got.found !== want.found || got.match_index !== want.match_index ||
                   got.pattern_error !== want.pattern_error) begin
                  if (mismatch_count < 10) begin
                     $write("%0t: result mismatch expected found=%0d index=%0d error=%0d, ",
                            $realtime, want.found, want.match_index, want.pattern_error);
                     $display("got found=%0d index=%0d error=%0d",
                              got.found, got.match_index, got.pattern_error);
                  end
                  mismatch_count++;
               end
            end
         end
      end
      pending_count = expected_q.size();
   end

endmodule

FILE: tb/forward_substring_search_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the forward substring search block: clock, reset, stimulus, verdict.
// Depends on fss_pkg, fss_if.sv, the block and forward_substring_search_checker.
module forward_substring_search_top_tb;

   localparam int PATTERN_MAX = 16;
   localparam int TEXT_MAX    = 65536;
   localparam fss_pkg::char_type LOWER_A = 16'h0061;
   localparam fss_pkg::char_type LOWER_Z = 16'h007A;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en;
   fss_pkg::csr_index_type csr_index;
   fss_pkg::char_type      csr_wr_data;
   int                     mismatch_count;
   int                     pending_count;
   bit                     tx_idle_en = 1'b1;
   bit                     rx_stall_en = 1'b1;
   int                     items_sent = 0;

   fss_req_if req_ch ();
   fss_rsp_if rsp_ch ();

   always #5 clock = ~clock;

   forward_substring_search_top #(
      .PATTERN_MAX (PATTERN_MAX),
      .TEXT_MAX    (TEXT_MAX)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   forward_substring_search_checker #(
      .PATTERN_MAX (PATTERN_MAX),
      .TEXT_MAX    (TEXT_MAX)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // Mostly short idle stretches, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 20);
   endfunction

   // Small alphabet for frequent hits, full 16-bit codes now and then
   function automatic fss_pkg::char_type pick_char();
      int r;
      r = $urandom_range(0, 19);
      case (r % 6)
         0: pick_char = LOWER_A;
         1: pick_char = LOWER_A + 16'd1;
         2: pick_char = fss_pkg::UPPER_A;
         3: pick_char = fss_pkg::UPPER_A + 16'd1;
         4: pick_char = fss_pkg::UPPER_Z;
         default: pick_char = LOWER_Z;
      endcase
      if (r >= 17) begin
         pick_char = fss_pkg::char_type'($urandom_range(0, 65535));
      end
   endfunction

   function automatic fss_pkg::char_type flip_case(input fss_pkg::char_type c);
      if (c >= fss_pkg::UPPER_A && c <= fss_pkg::UPPER_Z) begin
         return c + fss_pkg::CASE_OFFSET;
      end else if (c >= LOWER_A && c <= LOWER_Z) begin
         return c - fss_pkg::CASE_OFFSET;
      end
      return c;
   endfunction

   // Present one item at a falling edge and hold it until accepted
   task automatic send_item(input fss_pkg::req_kind_type kind, input fss_pkg::char_type code,
                            input logic last_flag);
      int gap;
      gap = tx_idle_en ? idle_len() : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.req_type  <= kind;
      req_ch.char_code <= code;
      req_ch.last_item <= last_flag;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_seq(input fss_pkg::req_kind_type kind, input fss_pkg::char_type seq[$],
                           input bit close);
      for (int i = 0; i < seq.size(); i++) begin
         send_item(kind, seq[i], close && i == seq.size() - 1);
      end
   endtask

   // Hold off the sender until every result is in and the pipeline has drained
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_config(input logic fold, input fss_pkg::pos_type offset);
      csr_wr_en   <= 1'b1;
      csr_index   <= fss_pkg::CSR_IGNORE_CASE;
      csr_wr_data <= {15'b0, fold};
      @(negedge clock);
      csr_index   <= fss_pkg::CSR_START_OFFSET;
      csr_wr_data <= offset;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Result receiver: random stalls, with stall-free stretches
   initial begin : receiver
      int stall_left;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (rx_stall_en && $urandom_range(0, 99) < 15) begin
               stall_left = idle_len();
            end
         end
      end
   end

   initial begin : stimulus
      fss_pkg::char_type pat[$];
      fss_pkg::char_type txt[$];
      int                base;
      int                search_no;
      int                plen;
      int                tlen;
      int                pos;
      int                r;
      bit                flip_some;
      bit                abort;
      fss_pkg::pos_type  offset;

      req_ch.valid     = 1'b0;
      req_ch.req_type  = fss_pkg::REQ_PATTERN;
      req_ch.char_code = '0;
      req_ch.last_item = 1'b0;
      csr_wr_en        = 1'b0;
      csr_index        = fss_pkg::CSR_IGNORE_CASE;
      csr_wr_data      = '0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Text before any pattern: never found
      send_seq(fss_pkg::REQ_TEXT, '{LOWER_A, LOWER_A}, 1'b1);
      // Extreme codes, second match stays silent
      send_seq(fss_pkg::REQ_PATTERN, '{16'h0000, 16'hFFFF}, 1'b1);
      send_seq(fss_pkg::REQ_TEXT, '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF}, 1'b1);
      // Pattern longer than the text
      send_seq(fss_pkg::REQ_PATTERN, '{LOWER_A, LOWER_A + 16'd1, LOWER_A + 16'd2}, 1'b1);
      send_seq(fss_pkg::REQ_TEXT, '{LOWER_A, LOWER_A + 16'd1}, 1'b1);

      // Folding at the edges of the capital range, match below the offset skipped
      wait_idle();
      write_config(1'b1, 16'd2);
      send_seq(fss_pkg::REQ_PATTERN, '{fss_pkg::UPPER_A, fss_pkg::UPPER_Z}, 1'b1);
      send_seq(fss_pkg::REQ_TEXT, '{LOWER_A, LOWER_Z, LOWER_A, LOWER_Z}, 1'b1);
      send_seq(fss_pkg::REQ_PATTERN, '{16'h0040, 16'h005B}, 1'b1);
      send_seq(fss_pkg::REQ_TEXT, '{16'h0060, 16'h007B, 16'h0040, 16'h005B}, 1'b1);

      // Offset beyond the text
      wait_idle();
      write_config(1'b0, 16'hFFFF);
      send_seq(fss_pkg::REQ_PATTERN, '{LOWER_A}, 1'b1);
      send_seq(fss_pkg::REQ_TEXT, '{LOWER_A, LOWER_A, LOWER_A}, 1'b1);

      // Random searches with occasional config changes
      base      = items_sent;
      search_no = 0;
      while (items_sent - base < 920) begin
         if (search_no % 6 == 0) begin
            wait_idle();
            r = $urandom_range(0, 9);
            if (r < 5) begin
               offset = '0;
            end else if (r < 9) begin
               offset = fss_pkg::pos_type'($urandom_range(1, 12));
            end else begin
               offset = fss_pkg::pos_type'($urandom_range(0, 65535));
            end
            write_config(logic'($urandom_range(0, 1)), offset);
            rx_stall_en = $urandom_range(0, 3) != 0;
         end
         tx_idle_en = $urandom_range(0, 3) != 0;

         // Raw noise items
         if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 4)) begin
               send_item(fss_pkg::req_kind_type'($urandom_range(0, 1)),
                         fss_pkg::char_type'($urandom_range(0, 65535)),
                         logic'($urandom_range(0, 1)));
            end
         end

         // Pattern, sometimes too long, sometimes left open
         r = $urandom_range(0, 9);
         if (r < 7) begin
            plen = $urandom_range(1, 6);
         end else if (r < 9) begin
            plen = $urandom_range(7, PATTERN_MAX);
         end else begin
            plen = $urandom_range(PATTERN_MAX + 1, PATTERN_MAX + 3);
         end
         pat.delete();
         repeat (plen) pat.push_back(pick_char());
         send_seq(fss_pkg::REQ_PATTERN, pat, $urandom_range(0, 9) != 0);

         // One to three texts, often carrying the pattern, sometimes cut short
         repeat ($urandom_range(1, 3)) begin
            tlen = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 20);
            txt.delete();
            repeat (tlen) txt.push_back(pick_char());
            if ($urandom_range(0, 9) < 7 && plen <= tlen) begin
               pos       = $urandom_range(0, tlen - plen);
               flip_some = $urandom_range(0, 1);
               for (int j = 0; j < plen; j++) begin
                  txt[pos + j] = (flip_some && $urandom_range(0, 1)) ? flip_case(pat[j]) : pat[j];
               end
            end
            abort = $urandom_range(0, 11) == 0;
            send_seq(fss_pkg::REQ_TEXT, txt, !abort);
            if (abort) begin
               break;
            end
         end
         search_no++;
      end

      // Drain and give the verdict
      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Stop a hung run
   initial begin : watchdog
      #6000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
